// ===== rtl/core/fcw_pkg.sv =====
// Shared types and constants of the FAT12 cluster chain walker.
// Used by fcw_front, fcw_back and the top level; depends on nothing.
package fcw_pkg;

   localparam int FAT_BYTES_DEFAULT = 8192;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [31:0] DATA_START_RESET    = 32'd16896;
   localparam logic [16:0] CLUSTER_BYTES_RESET = 17'd512;

   // request commands
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_OPEN   = 2'd1;
   localparam logic [1:0] CMD_NEXT   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_DATA_START    = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_BYTES = 2'd1;

   // FAT12 link values
   localparam logic [11:0] LINK_RESERVED = 12'hFF0;
   localparam logic [11:0] LINK_END      = 12'hFF8;
   localparam logic [11:0] LINK_FREE     = 12'h000;
   localparam logic [11:0] CLUSTER_FIRST = 12'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [12:0] fat_byte_index;
      logic [7:0]  fat_byte_value;
      logic [11:0] start_cluster;
      logic [31:0] file_bytes;
      logic        deleted_flag;
   } fcw_entry_type;

   typedef struct packed {
      logic          valid;
      fcw_entry_type entry;
   } fcw_head_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [31:0] wdata;
   } fcw_csr_type;

endpackage

// ===== rtl/core/fcw_front.sv =====
// Front end: accepts requests, drops unused commands, queues the rest.
// Depends on fcw_pkg.
module fcw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [12:0]           req_fat_byte_index,
   input  logic [7:0]            req_fat_byte_value,
   input  logic [11:0]           req_start_cluster,
   input  logic [31:0]           req_file_bytes,
   input  logic                  req_deleted_flag,
   output fcw_pkg::fcw_head_type head,
   input  logic                  pop
);

   localparam int DEPTH = fcw_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   fcw_pkg::fcw_entry_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   fcw_pkg::fcw_entry_type new_entry;

   assign req_stall = (count_ff == FULL_CNT);
   // unused command is taken and dropped here
   assign push = req_valid && !req_stall && (req_cmd != fcw_pkg::CMD_UNUSED);

   assign new_entry.cmd            = req_cmd;
   assign new_entry.fat_byte_index = req_fat_byte_index;
   assign new_entry.fat_byte_value = req_fat_byte_value;
   assign new_entry.start_cluster  = req_start_cluster;
   assign new_entry.file_bytes     = req_file_bytes;
   assign new_entry.deleted_flag   = req_deleted_flag;

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      case ({push, pop})
         2'b10:   count_in = CW'(count_ff + 1'b1);
         2'b01:   count_in = CW'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("push lost in queue count");

endmodule

// ===== rtl/core/fcw_back.sv =====
// Back end: FAT byte memory, walk state, registers and result register.
// Reads two FAT bytes per link over one read port. Depends on fcw_pkg.
module fcw_back #(
   parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fcw_pkg::fcw_head_type head,
   output logic                  pop,
   input  fcw_pkg::fcw_csr_type  csr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_extent_valid,
   output logic [31:0]           rsp_byte_offset,
   output logic [16:0]           rsp_byte_count
);

   localparam int AW = $clog2(FAT_BYTES);
   localparam logic [13:0] FAT_LIMIT = 14'(FAT_BYTES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RD_HI = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   logic [7:0]    fat_mem [FAT_BYTES];
   logic [7:0]    rd_data_ff;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;

   logic [1:0]  state_ff, state_in;
   logic [11:0] cluster_ff, cluster_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] target_ff, target_in;
   logic        deleted_ff, deleted_in;
   logic        active_ff, active_in;
   logic [12:0] pos_ff, pos_in;
   logic        lo_ok_ff, lo_ok_in;
   logic        hi_ok_ff, hi_ok_in;
   logic [7:0]  lo_ff, lo_in;
   logic [31:0] left_ff, left_in;
   logic [28:0] prod_ff, prod_in;
   logic [31:0] data_start_ff, data_start_in;
   logic [16:0] cluster_bytes_ff, cluster_bytes_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        ext_ff, ext_in;
   logic [31:0] offset_ff, offset_in;
   logic [16:0] count_ff, count_in;

   logic        out_free;
   logic [12:0] pos_now, pos_hi;
   logic [7:0]  hi_byte;
   logic [11:0] link;
   logic [11:0] cluster_rel, cluster_next;
   logic [16:0] extent_cnt;
   logic [31:0] extent_offset;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // byte position of a 12-bit entry: cluster * 3 / 2
   assign pos_now  = {1'b0, cluster_ff} + {2'b0, cluster_ff[11:1]};
   assign pos_hi   = 13'(pos_ff + 1'b1);
   assign hi_byte  = hi_ok_ff ? rd_data_ff : 8'h00;
   assign link     = cluster_ff[0] ? {hi_byte, lo_ff[7:4]} : {hi_byte[3:0], lo_ff};
   assign cluster_rel   = 12'(cluster_ff - fcw_pkg::CLUSTER_FIRST);
   assign cluster_next  = 12'(cluster_ff + 1'b1);
   assign extent_cnt    = (left_ff < {15'b0, cluster_bytes_ff}) ? left_ff[16:0]
                                                                : cluster_bytes_ff;
   assign extent_offset = 32'(data_start_ff + {3'b0, prod_ff});

   always_comb begin
      state_in         = state_ff;
      cluster_in       = cluster_ff;
      done_in          = done_ff;
      target_in        = target_ff;
      deleted_in       = deleted_ff;
      active_in        = active_ff;
      pos_in           = pos_ff;
      lo_ok_in         = lo_ok_ff;
      hi_ok_in         = hi_ok_ff;
      lo_in            = lo_ff;
      left_in          = left_ff;
      prod_in          = prod_ff;
      data_start_in    = data_start_ff;
      cluster_bytes_in = cluster_bytes_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      ext_in           = ext_ff;
      offset_in        = offset_ff;
      count_in         = count_ff;
      pop              = 1'b0;
      wr_en            = 1'b0;
      wr_addr          = head.entry.fat_byte_index[AW-1:0];
      rd_en            = 1'b0;
      rd_addr          = pos_now[AW-1:0];

      if (csr.valid) begin
         unique case (csr.index)
            fcw_pkg::CSR_DATA_START:    data_start_in    = csr.wdata;
            fcw_pkg::CSR_CLUSTER_BYTES: cluster_bytes_in = csr.wdata[16:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.entry.cmd)
                  fcw_pkg::CMD_LOAD: begin
                     pop   = 1'b1;
                     wr_en = ({1'b0, head.entry.fat_byte_index} < FAT_LIMIT);
                  end
                  fcw_pkg::CMD_OPEN: begin
                     pop        = 1'b1;
                     cluster_in = head.entry.start_cluster;
                     target_in  = head.entry.file_bytes;
                     deleted_in = head.entry.deleted_flag;
                     done_in    = '0;
                     active_in  = (head.entry.start_cluster >= fcw_pkg::CLUSTER_FIRST);
                  end
                  fcw_pkg::CMD_NEXT: begin
                     if (!active_ff || (done_ff >= target_ff)) begin
                        // file finished: report without touching the FAT
                        if (out_free) begin
                           pop          = 1'b1;
                           active_in    = 1'b0;
                           rsp_valid_in = 1'b1;
                           ext_in       = 1'b0;
                           offset_in    = '0;
                           count_in     = '0;
                        end
                     end else begin
                        pop      = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = pos_now[AW-1:0];
                        pos_in   = pos_now;
                        lo_ok_in = ({1'b0, pos_now} < FAT_LIMIT);
                        state_in = ST_RD_HI;
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_RD_HI: begin
            rd_en    = 1'b1;
            rd_addr  = pos_hi[AW-1:0];
            hi_ok_in = ({1'b0, pos_hi} < FAT_LIMIT);
            lo_in    = lo_ok_ff ? rd_data_ff : 8'h00;
            left_in  = 32'(target_ff - done_ff);
            prod_in  = {17'b0, cluster_rel} * {12'b0, cluster_bytes_ff};
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // hold until the result register is free
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               ext_in       = 1'b0;
               offset_in    = '0;
               count_in     = '0;
               if (deleted_ff) begin
                  if ((link != fcw_pkg::LINK_FREE) && (link < fcw_pkg::LINK_END)) begin
                     active_in = 1'b0;
                  end else begin
                     ext_in     = 1'b1;
                     offset_in  = extent_offset;
                     count_in   = extent_cnt;
                     done_in    = 32'(done_ff + {15'b0, extent_cnt});
                     cluster_in = cluster_next;
                     if ((cluster_next >= fcw_pkg::LINK_RESERVED) ||
                         (cluster_next < fcw_pkg::CLUSTER_FIRST)) begin
                        active_in = 1'b0;
                     end
                  end
               end else begin
                  if ((cluster_ff < fcw_pkg::CLUSTER_FIRST) ||
                      (cluster_ff >= fcw_pkg::LINK_RESERVED)) begin
                     active_in = 1'b0;
                  end else begin
                     ext_in    = 1'b1;
                     offset_in = extent_offset;
                     count_in  = extent_cnt;
                     done_in   = 32'(done_ff + {15'b0, extent_cnt});
                     if ((link >= fcw_pkg::LINK_RESERVED) ||
                         (link < fcw_pkg::CLUSTER_FIRST)) begin
                        active_in = 1'b0;
                     end else begin
                        cluster_in = link;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cluster_ff       <= '0;
         done_ff          <= '0;
         target_ff        <= '0;
         deleted_ff       <= 1'b0;
         active_ff        <= 1'b0;
         data_start_ff    <= fcw_pkg::DATA_START_RESET;
         cluster_bytes_ff <= fcw_pkg::CLUSTER_BYTES_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cluster_ff       <= cluster_in;
         done_ff          <= done_in;
         target_ff        <= target_in;
         deleted_ff       <= deleted_in;
         active_ff        <= active_in;
         data_start_ff    <= data_start_in;
         cluster_bytes_ff <= cluster_bytes_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      lo_ok_ff  <= lo_ok_in;
      hi_ok_ff  <= hi_ok_in;
      lo_ff     <= lo_in;
      left_ff   <= left_in;
      prod_ff   <= prod_in;
      ext_ff    <= ext_in;
      offset_ff <= offset_in;
      count_ff  <= count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fat_mem[wr_addr] <= head.entry.fat_byte_value;
      end
      if (rd_en) begin
         rd_data_ff <= fat_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_extent_valid = ext_ff;
   assign rsp_byte_offset  = offset_ff;
   assign rsp_byte_count   = count_ff;

   a_active_cluster: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cluster_ff >= fcw_pkg::CLUSTER_FIRST))
      else $error("active walk on a cluster below two");

   a_done_le_target: assert property (@(posedge clock) disable iff (reset)
      done_ff <= target_ff)
      else $error("bytes done past file size");

   a_rd_hi_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_HI) |-> ($past(state_ff) == ST_IDLE))
      else $error("second FAT read without first");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head.valid && (state_ff == ST_IDLE)))
      else $error("request popped outside idle");

endmodule

// ===== rtl/core/fat12_cluster_chain_walker_top.sv =====
// Top level of the FAT12 cluster chain walker.
// Instantiates fcw_front and fcw_back; depends on fcw_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cmd, FAT byte, open fields
//   rsp      out        rsp_valid/rsp_stall  extent_valid, byte_offset, byte_count
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// FAT load and open are done in the idle state, as is a next request that finds
// the file finished; any other next does two byte reads in series on the FAT
// memory's single read port, then link decode and result write (eval state).
// A two-entry queue parts request intake from the walker; req_stall rises when
// it is full. rsp_stall holds the result register and the walker behind it.
// Reset is synchronous, clears walk state and sets the registers to their defaults;
// FAT bytes are not cleared and must be loaded before they are read.
module fat12_cluster_chain_walker_top #(
   parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [12:0] req_fat_byte_index,
   input  logic [7:0]  req_fat_byte_value,
   input  logic [11:0] req_start_cluster,
   input  logic [31:0] req_file_bytes,
   input  logic        req_deleted_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_extent_valid,
   output logic [31:0] rsp_byte_offset,
   output logic [16:0] rsp_byte_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   fcw_pkg::fcw_head_type head;
   fcw_pkg::fcw_csr_type  csr;
   logic                  pop;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   fcw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_fat_byte_index (req_fat_byte_index),
      .req_fat_byte_value (req_fat_byte_value),
      .req_start_cluster  (req_start_cluster),
      .req_file_bytes     (req_file_bytes),
      .req_deleted_flag   (req_deleted_flag),
      .head               (head),
      .pop                (pop)
   );

   fcw_back #(
      .FAT_BYTES (FAT_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .csr              (csr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_extent_valid (rsp_extent_valid),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_byte_count   (rsp_byte_count)
   );

endmodule
